>>> rtl/sdmn_pkg.sv
package sdmn_pkg;

    localparam int unsigned W_DATA = 32;
    localparam int unsigned W_SHIFT = 6;
    localparam int unsigned W_ASIGN = 2;
    localparam int unsigned W_POW = 6;
    localparam int unsigned W_CNT = 5;

    localparam logic [W_DATA-1:0] TWO31 = 32'h8000_0000;
    localparam logic [W_POW-1:0] P_START = 6'd31;
    localparam logic [W_POW-1:0] P_LIMIT = 6'd63;
    localparam logic [W_POW-1:0] P_BIAS = 6'd32;
    localparam logic [W_CNT-1:0] CNT_LAST = 5'd31;

    localparam logic [W_SHIFT-1:0] SHIFT_UNIT = 6'h3F;
    localparam logic [W_ASIGN-1:0] ASIGN_NONE = 2'b00;
    localparam logic [W_ASIGN-1:0] ASIGN_ADD = 2'b01;
    localparam logic [W_ASIGN-1:0] ASIGN_SUB = 2'b11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_ANC,
        ST_DIV1,
        ST_DIV2,
        ST_REF1,
        ST_REF2,
        ST_TEST,
        ST_FIN
    } t_state;

endpackage

>>> rtl/sdmn_step.sv
module sdmn_step
    import sdmn_pkg::*;
(
    input  logic [W_DATA-1:0] i_rem,
    input  logic [W_DATA-1:0] i_quo,
    input  logic [W_DATA-1:0] i_den,
    input  logic              i_bit,
    output logic [W_DATA-1:0] o_rem,
    output logic [W_DATA-1:0] o_quo
);

    logic [W_DATA:0]   rem_sh;
    logic [W_DATA-1:0] rem_sub;
    logic              ge;

    // one restoring step: shift in a bit, subtract if it fits
    assign rem_sh  = {i_rem, i_bit};
    assign ge      = rem_sh >= {1'b0, i_den};
    assign rem_sub = rem_sh[W_DATA-1:0] - i_den;
    assign o_rem   = ge ? rem_sub : rem_sh[W_DATA-1:0];
    assign o_quo   = {i_quo[W_DATA-2:0], ge};

endmodule

>>> rtl/signed_div_magic_number.sv
// signed division magic-number generator, 32 bit
//
// slave channel: one beat carries a signed 32-bit divisor; master channel:
// one beat carries the magic multiplier, the post-shift and the add/subtract
// correction that turn a signed divide into multiply-high, add and shift
//
// the divisions run through one shift-compare-subtract step unit under a
// small sequencer: t mod |d|, anc, 2^31 / anc, 2^31 / |d|, then refinement
// iterations of two steps and a delta test each, then the final step; the
// refinement loop runs 1 to 32 iterations; divisors +1 and -1 skip the search
// and go straight to the final step
// one divisor is in work at a time; o_s_tready is high only while idle
//
// the result sits in an output register; the sequencer goes back to idle
// as soon as the result is loaded, so a new divisor is taken while the
// previous result still waits; if the receiver stalls with a result held,
// the next result waits in the final step until the register frees up
//
// reset (synchronous, active low) empties the output register and returns
// the sequencer to idle; the datapath registers are not cleared
module signed_div_magic_number
    import sdmn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] divisor
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [31:0] multiplier, [37:32] shift, [39:38] add_sign
);

    t_state r_state, n_state;

    logic [W_DATA-1:0] r_mag, n_mag;
    logic [W_DATA-1:0] r_anc, n_anc;
    logic [W_DATA-1:0] r_q1, n_q1;
    logic [W_DATA-1:0] r_r1, n_r1;
    logic [W_DATA-1:0] r_q2, n_q2;
    logic [W_DATA-1:0] r_r2, n_r2;
    logic [W_POW-1:0]  r_p, n_p;
    logic [W_CNT-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_zero, n_zero;
    logic              r_unit, n_unit;

    logic              r_out_valid, n_out_valid;
    logic [39:0]       r_out_data, n_out_data;

    // shared step unit operands
    logic [W_DATA-1:0] u_rem, u_quo, u_den, u_rem_n, u_quo_n;
    logic              u_bit;

    logic              in_beat;
    logic              out_free;
    logic              cnt_done;
    logic              keep_going;
    logic [W_DATA-1:0] delta;
    logic [W_DATA-1:0] anc_raw;
    logic [W_DATA-1:0] mul_pos;
    logic [W_DATA-1:0] mul;
    logic [W_ASIGN-1:0] asg;
    logic [W_SHIFT-1:0] sft;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_beat    = i_s_tvalid & o_s_tready;
    assign out_free   = ~r_out_valid | i_m_tready;
    assign cnt_done   = (r_cnt == CNT_LAST);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    sdmn_step u_step (
        .i_rem (u_rem),
        .i_quo (u_quo),
        .i_den (u_den),
        .i_bit (u_bit),
        .o_rem (u_rem_n),
        .o_quo (u_quo_n)
    );

    // delta test of the refinement loop
    assign delta      = r_mag - r_r2;
    assign keep_going = (r_q1 < delta) || ((r_q1 == delta) && (r_r1 == '0));

    // anc = t - 1 - t mod |d|, t - 1 = 2^31 - 1 + sign
    assign anc_raw = 32'h7FFF_FFFF + {31'd0, r_neg} - r_r1;

    // final result
    assign mul_pos = r_q2 + 32'd1;
    assign mul     = r_neg ? (32'd0 - mul_pos) : mul_pos;
    assign sft     = r_p - P_BIAS;

    always_comb begin
        if (!r_neg && !r_zero && mul[31]) begin
            asg = ASIGN_ADD;
        end else if (r_neg && (mul != '0) && !mul[31]) begin
            asg = ASIGN_SUB;
        end else begin
            asg = ASIGN_NONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if ((i_s_tdata == 32'd1) || (i_s_tdata == 32'hFFFF_FFFF)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD:  if (cnt_done) n_state = ST_ANC;
            ST_ANC:  n_state = ST_DIV1;
            ST_DIV1: if (cnt_done) n_state = ST_DIV2;
            ST_DIV2: if (cnt_done) n_state = ST_REF1;
            ST_REF1: n_state = ST_REF2;
            ST_REF2: n_state = ST_TEST;
            ST_TEST: begin
                if (!keep_going || (r_p >= P_LIMIT)) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_REF1;
                end
            end
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mag       = r_mag;
        n_anc       = r_anc;
        n_q1        = r_q1;
        n_r1        = r_r1;
        n_q2        = r_q2;
        n_r2        = r_r2;
        n_p         = r_p;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_unit      = r_unit;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;

        u_rem = r_r1;
        u_quo = r_q1;
        u_den = r_anc;
        u_bit = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_neg  = i_s_tdata[31];
                    n_zero = (i_s_tdata == '0);
                    n_unit = (i_s_tdata == 32'd1) || (i_s_tdata == 32'hFFFF_FFFF);
                    if (i_s_tdata == '0) begin
                        n_mag = 32'd1;
                    end else if (i_s_tdata[31]) begin
                        n_mag = 32'd0 - i_s_tdata;
                    end else begin
                        n_mag = i_s_tdata;
                    end
                    // dividend t = 2^31 + sign bit
                    n_q1  = TWO31 | {31'd0, i_s_tdata[31]};
                    n_r1  = '0;
                    n_cnt = '0;
                end
            end
            ST_MOD: begin
                u_rem = r_r1;
                u_quo = r_q1;
                u_den = r_mag;
                u_bit = r_q1[31];
                n_r1  = u_rem_n;
                n_q1  = u_quo_n;
                n_cnt = r_cnt + 5'd1;
            end
            ST_ANC: begin
                n_anc = (anc_raw == '0) ? 32'd1 : anc_raw;
                n_q1  = TWO31;
                n_r1  = '0;
                n_q2  = TWO31;
                n_r2  = '0;
                n_p   = P_START;
                n_cnt = '0;
            end
            ST_DIV1: begin
                u_rem = r_r1;
                u_quo = r_q1;
                u_den = r_anc;
                u_bit = r_q1[31];
                n_r1  = u_rem_n;
                n_q1  = u_quo_n;
                n_cnt = r_cnt + 5'd1;
            end
            ST_DIV2: begin
                u_rem = r_r2;
                u_quo = r_q2;
                u_den = r_mag;
                u_bit = r_q2[31];
                n_r2  = u_rem_n;
                n_q2  = u_quo_n;
                n_cnt = r_cnt + 5'd1;
            end
            ST_REF1: begin
                u_rem = r_r1;
                u_quo = r_q1;
                u_den = r_anc;
                n_r1  = u_rem_n;
                n_q1  = u_quo_n;
                n_p   = r_p + 6'd1;
            end
            ST_REF2: begin
                u_rem = r_r2;
                u_quo = r_q2;
                u_den = r_mag;
                n_r2  = u_rem_n;
                n_q2  = u_quo_n;
            end
            ST_TEST: begin
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_unit) begin
                        n_out_data = {(r_neg ? ASIGN_SUB : ASIGN_ADD), SHIFT_UNIT, 32'd0};
                    end else begin
                        n_out_data = {asg, sft, mul};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_anc      <= n_anc;
        r_q1       <= n_q1;
        r_r1       <= n_r1;
        r_q2       <= n_q2;
        r_r2       <= n_r2;
        r_p        <= n_p;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_unit     <= n_unit;
        r_out_data <= n_out_data;
    end

endmodule

>>> rtl/sdmn_checker.sv
module sdmn_checker
    import sdmn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    // a held result stays put
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one divisor at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("beat taken while busy");

    // unit shift only comes with a zero multiplier and a correction
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[37:32] == SHIFT_UNIT) |->
            (o_m_tdata[31:0] == 32'd0) && (o_m_tdata[39:38] != ASIGN_NONE))
        else $error("bad unit-divisor result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind signed_div_magic_number sdmn_checker u_sdmn_checker (.*);

>>> tb/sv/tb_signed_div_magic_number.sv
`timescale 1ns / 100ps

module tb_signed_div_magic_number;
    import sdmn_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 250;  // quiet time after the last owed result before the verdict

    // one result beat, multiplier in the lowest bits
    typedef struct packed {
        logic [W_ASIGN-1:0] add_sign;
        logic [W_SHIFT-1:0] shift;
        logic [W_DATA-1:0]  multiplier;
    } magic_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] divisor
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] multiplier, [37:32] shift, [39:38] add_sign

    magic_t magic_due[$];          // magic numbers still owed by the block
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;

    // receiver stall pattern state
    int     ready_mode = 0;
    int     mode_left = 0;
    int     hold_left = 0;

    signed_div_magic_number DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // magic multiplier, post-shift and correction sign for one divisor
    function automatic magic_t compute_magic(input logic [31:0] dv);
        magic_t res;
        logic neg;
        logic [31:0] mag, t, anc, q1, r1, q2, r2, delta, mul;
        int p;
        bit done;
        res = '0;
        neg = dv[31];
        // plus and minus one bypass the search
        if (dv == 32'd1 || dv == 32'hFFFF_FFFF) begin
            res.shift = SHIFT_UNIT;
            res.add_sign = (dv == 32'd1) ? ASIGN_ADD : ASIGN_SUB;
            return res;
        end
        // zero divisor counts as magnitude one
        if (dv == '0)
            mag = 32'd1;
        else
            mag = neg ? (32'd0 - dv) : dv;
        t = TWO31 + {31'd0, dv[31]};
        anc = t - 32'd1 - (t % mag);
        if (anc == '0)
            anc = 32'd1;
        p = int'(P_START);
        q1 = TWO31 / anc;
        r1 = TWO31 - q1 * anc;
        q2 = TWO31 / mag;
        r2 = TWO31 - q2 * mag;
        done = 1'b0;
        while (!done) begin
            p++;
            q1 = q1 << 1;
            r1 = r1 << 1;
            if (r1 >= anc) begin
                q1 = q1 + 32'd1;
                r1 = r1 - anc;
            end
            q2 = q2 << 1;
            r2 = r2 << 1;
            if (r2 >= mag) begin
                q2 = q2 + 32'd1;
                r2 = r2 - mag;
            end
            delta = mag - r2;
            done = !(q1 < delta || (q1 == delta && r1 == '0)) || p >= int'(P_LIMIT);
        end
        mul = q2 + 32'd1;
        if (neg)
            mul = 32'd0 - mul;
        res.multiplier = mul;
        res.shift = W_SHIFT'(p - int'(P_BIAS));
        if (!neg && dv != '0 && mul[31])
            res.add_sign = ASIGN_ADD;
        else if (neg && mul != '0 && !mul[31])
            res.add_sign = ASIGN_SUB;
        else
            res.add_sign = ASIGN_NONE;
        return res;
    endfunction

    // one divisor beat; sender runs in bursts with random gaps afterwards
    task automatic send_divisor(input logic [31:0] dv);
        int gap;
        int pick;
        s_tvalid <= 1'b1;
        s_tdata <= dv;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        magic_due.push_back(compute_magic(dv));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 30);
            else
                gap = $urandom_range(31, 220);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] random_sign(input logic [31:0] mag);
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic test_directed_divisors();
        logic [31:0] corner[24];
        corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3,
                   32'hFFFF_FFFD, 32'd5, 32'd6, 32'd7, 32'hFFFF_FFF9, 32'd25,
                   32'd125, 32'd641, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                   32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFE, 32'h0001_0000,
                   32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corner[i])
            send_divisor(corner[i]);
    endtask

    task automatic test_small_magnitudes(input int count);
        repeat (count)
            send_divisor(random_sign($urandom_range(0, 2000)));
    endtask

    // powers of two and their close neighbors
    task automatic test_power_of_two_neighbors(input int count);
        int k;
        logic [31:0] mag;
        repeat (count) begin
            k = $urandom_range(1, 31);
            mag = (32'd1 << k) + 32'($urandom_range(0, 6)) - 32'd3;
            send_divisor(random_sign(mag));
        end
    endtask

    task automatic test_full_range(input int count);
        repeat (count)
            send_divisor($urandom());
    endtask

    // sender holds off until every owed result is out, then resumes
    task automatic test_drain_pause(input int count);
        repeat (count / 2)
            send_divisor($urandom());
        s_tvalid <= 1'b0;
        while (magic_due.size() != 0)
            @(posedge clk);
        repeat (count - count / 2)
            send_divisor(random_sign($urandom_range(0, 300)));
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk) begin : result_check
        magic_t seen;
        magic_t want;
        logic next_ready;
        if (rst_n && m_tvalid && m_tready) begin
            seen = magic_t'(m_tdata);
            if (magic_due.size() == 0) begin
                $display("%0t: result beat with none owed, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = magic_due.pop_front();
                if (seen.multiplier !== want.multiplier) begin
                    $display("%0t: multiplier expected %h got %h",
                             $time, want.multiplier, seen.multiplier);
                    mismatch_count++;
                end
                if (seen.shift !== want.shift) begin
                    $display("%0t: shift expected %h got %h", $time, want.shift, seen.shift);
                    mismatch_count++;
                end
                if (seen.add_sign !== want.add_sign) begin
                    $display("%0t: add_sign expected %h got %h",
                             $time, want.add_sign, seen.add_sign);
                    mismatch_count++;
                end
            end
        end

        // modes: always ready, coin flip, long holds with short windows
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(200, 2000);
            hold_left = 0;
        end else begin
            mode_left--;
        end
        next_ready = m_tready;
        case (ready_mode)
            0: next_ready = 1'b1;
            1: next_ready = $urandom_range(0, 1);
            default: begin
                if (hold_left == 0) begin
                    next_ready = ~m_tready;
                    hold_left = m_tready ? $urandom_range(20, 300) : $urandom_range(1, 5);
                end else begin
                    hold_left--;
                end
            end
        endcase
        m_tready <= next_ready;
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("signed_div_magic_number verification failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_divisors();
        test_small_magnitudes(300);
        test_power_of_two_neighbors(250);
        test_drain_pause(30);
        test_full_range(500);

        s_tvalid <= 1'b0;
        while (magic_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("signed_div_magic_number verification clean");
        else
            $display("signed_div_magic_number verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/sdmn_pkg.sv
rtl/sdmn_step.sv
rtl/signed_div_magic_number.sv
rtl/sdmn_checker.sv
tb/sv/tb_signed_div_magic_number.sv
